>>> design/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg: shared types and codes for the ordered list table
// Request and response payloads, action and status codes, cell controls.
// ----------------------------------------------------------------------------
package olt_pkg;

  // Action codes carried by a request
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // Status codes carried by a response
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic cmp;     // register the match flag against the key
    logic append;  // first empty cell takes the key
    logic shift;   // marked cells take their right neighbor's contents
  } cell_ctrl_t;

endpackage

>>> design/olt_cell.sv
// ----------------------------------------------------------------------------
// olt_cell: one slot of the ordered list
// Holds one entry and its valid flag, compares against the broadcast key,
// and takes its right neighbor's contents when the list closes a gap.
// ----------------------------------------------------------------------------
module olt_cell
  import olt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  logic [VALUE_W-1:0] key,
  input  logic               shift_sel,   // this cell sits at or after the hit
  input  logic               prev_valid,  // left neighbor holds an entry
  input  logic               next_valid,  // right neighbor holds an entry
  input  logic [VALUE_W-1:0] next_data,
  output logic               valid,
  output logic [VALUE_W-1:0] data,
  output logic               hit
);

  logic is_tail_slot;

  // First empty slot: this one is empty and everything to the left is full
  assign is_tail_slot = !valid && prev_valid;

  // Valid flag: control state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.append && is_tail_slot) begin
      valid <= 1'b1;
    end else if (ctrl.shift && shift_sel) begin
      valid <= next_valid;
    end
  end

  // Entry payload and match flag
  always_ff @(posedge clk) begin
    if (ctrl.append && is_tail_slot) begin
      data <= key;
    end else if (ctrl.shift && shift_sel) begin
      data <= next_data;
    end
    if (ctrl.cmp) begin
      hit <= valid && (data == key);
    end
  end

endmodule

>>> design/olt_ctrl.sv
// ----------------------------------------------------------------------------
// olt_ctrl: request sequencer for the ordered list
// Takes a request, broadcasts the compare, picks the first matching cell,
// drives the append or gap-closing shift and builds the response.
// ----------------------------------------------------------------------------
module olt_ctrl
  import olt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  req_t                req,
  output logic                busy,
  output logic                done,
  output rsp_t                rsp,
  input  logic [CAPACITY-1:0] hit_vec,
  output cell_ctrl_t          ctrl,
  output logic [CAPACITY-1:0] shift_sel,
  output logic [VALUE_W-1:0]  key
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_PICK,
    S_APPLY
  } state_t;

  state_t             state;
  logic [1:0]         act;
  logic [OCC_W-1:0]   occ;
  logic [OCC_W-1:0]   occ_next;
  logic               found;
  logic [IDX_W-1:0]   hit_pos;
  logic [CAPACITY-1:0] first_hit;
  logic [IDX_W-1:0]   first_pos;
  logic               accept;
  logic               full;
  logic [1:0]         status_now;
  logic [IDX_W-1:0]   pos_now;
  logic [31:0]        pos_ext;
  logic [31:0]        cnt_ext;

  assign busy   = (state == S_MATCH) || (state == S_PICK);
  assign accept = start && !busy;
  assign done   = (state == S_APPLY);
  assign full   = (occ == OCC_W'(CAPACITY));

  // Lowest set match bit, one-hot, then its index
  assign first_hit = hit_vec & (~hit_vec + CAPACITY'(1));

  always_comb begin
    first_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) begin
        first_pos = first_pos | IDX_W'(i);
      end
    end
  end

  // Cell controls
  always_comb begin
    ctrl.cmp    = (state == S_MATCH);
    ctrl.append = (state == S_APPLY) && (act == ACT_APPEND) && !full;
    ctrl.shift  = (state == S_APPLY) && (act == ACT_DELETE) && found;
  end

  // Outcome of the request in the apply cycle
  always_comb begin
    status_now = ST_MISSING;
    pos_now    = '0;
    occ_next   = occ;
    unique case (act)
      ACT_APPEND: begin
        if (full) begin
          status_now = ST_FULL;
        end else begin
          status_now = ST_OK;
          pos_now    = IDX_W'(occ);
          occ_next   = occ + OCC_W'(1);
        end
      end
      ACT_DELETE: begin
        if (found) begin
          status_now = ST_OK;
          pos_now    = hit_pos;
          occ_next   = occ - OCC_W'(1);
        end
      end
      ACT_LOOKUP: begin
        if (found) begin
          status_now = ST_OK;
          pos_now    = hit_pos;
        end
      end
      default: begin
        status_now = ST_MISSING;
      end
    endcase
  end

  assign pos_ext = 32'(pos_now);
  assign cnt_ext = 32'(occ_next);

  always_comb begin
    rsp.status   = status_now;
    rsp.position = pos_ext[POS_W-1:0];
    rsp.count    = cnt_ext[COUNT_W-1:0];
  end

  // Sequencer state and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_PICK;
        end
        S_PICK: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          occ   <= occ_next;
          state <= accept ? S_MATCH : S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request payload and match selection
  always_ff @(posedge clk) begin
    if (accept) begin
      act <= req.action;
      key <= req.value;
    end
    if (state == S_PICK) begin
      found     <= |hit_vec;
      hit_pos   <= first_pos;
      // cells at or after the first match close the gap
      shift_sel <= ~(first_hit - CAPACITY'(1));
    end
  end

endmodule

>>> design/ordered_list_table.sv
// ----------------------------------------------------------------------------
// ordered_list_table: insertion-ordered list with append, delete, lookup
// Each start transfer runs through the compare, first-match pick and apply
// states over the cell row; the response strobe (done) marks the apply state.
// Busy covers the compare and pick states, and a new start is taken in the
// cycle that carries done.
// Reset (rst, synchronous): list empty, count 0; entry contents are kept.
// ----------------------------------------------------------------------------
module ordered_list_table
  import olt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  cell_ctrl_t          ctrl;
  logic [VALUE_W-1:0]  key;
  logic [CAPACITY-1:0] shift_sel;
  logic [CAPACITY-1:0] valid;
  logic [CAPACITY-1:0] hit;
  logic [VALUE_W-1:0]  cell_data [CAPACITY];

  // Request sequencer
  olt_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .done     (done),
    .rsp      (rsp),
    .hit_vec  (hit),
    .ctrl     (ctrl),
    .shift_sel(shift_sel),
    .key      (key)
  );

  // Row of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               prev_v;
    logic               next_v;
    logic [VALUE_W-1:0] next_d;

    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_v = 1'b0;
      assign next_d = '0;
    end else begin : g_link
      assign next_v = valid[i+1];
      assign next_d = cell_data[i+1];
    end

    olt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .key       (key),
      .shift_sel (shift_sel[i]),
      .prev_valid(prev_v),
      .next_valid(next_v),
      .next_data (next_d),
      .valid     (valid[i]),
      .data      (cell_data[i]),
      .hit       (hit[i])
    );
  end

endmodule

>>> design/olt_checker.sv
// ----------------------------------------------------------------------------
// olt_checker: port-level checks for the ordered list table
// Watches the request and response ports and is bound to the top level.
// ----------------------------------------------------------------------------
module olt_checker
  import olt_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  // Every transfer gets its response once the compare and pick states are through
  a_fixed_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("response missing three cycles after a transfer");

  // A transfer always makes the table busy on the next cycle
  a_busy_after_start : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("table not busy after a transfer");

  // A response is never shown while the table is busy
  a_done_not_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("response strobe while busy");

  // Failed requests report position zero and a defined status
  a_status_pos : assert property (@(posedge clk) disable iff (rst)
    done |-> ((rsp.status == ST_OK) ||
              (((rsp.status == ST_MISSING) || (rsp.status == ST_FULL)) &&
               (rsp.position == '0))))
    else $error("bad status or nonzero position on a failed request");

endmodule

bind ordered_list_table olt_checker u_olt_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);
